@@ hdl/gcfw_pkg.sv @@
// Shared types, constants and helpers for the glyph cell framebuffer writer.
// No dependencies; every other file refers to this package by scoped names.
package gcfw_pkg;

  // Glyph geometry: cells are always eight pixels wide
  localparam int CELL_WIDTH      = 8;
  localparam int CELL_HEIGHT_DEF = 16;
  localparam int STEP_W          = $clog2(CELL_WIDTH + 1);
  localparam int COL_SHIFT       = $clog2(CELL_WIDTH);
  localparam int PX_OFF_W        = 8 + COL_SHIFT + 3;

  // Request queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_READY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMEBUFFER_BASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COMMIT_THRESHOLD = 3'd4;

  // Configuration reset values
  localparam logic        RST_DISPLAY_READY    = 1'b0;
  localparam logic [2:0]  RST_BYTES_PER_PIXEL  = 3'd4;
  localparam logic [15:0] RST_LINE_PITCH       = 16'd4096;
  localparam logic [31:0] RST_FRAMEBUFFER_BASE = 32'd0;
  localparam logic [31:0] RST_COMMIT_THRESHOLD = 32'd4096;

  typedef enum logic [1:0] {
    OP_GLYPH = 2'd0,
    OP_BEGIN = 2'd1,
    OP_END   = 2'd2,
    OP_FLUSH = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_FRAME  = 2'd1,
    KIND_COMMIT = 2'd2
  } kind_t;

  // Live configuration seen by front and back
  typedef struct packed {
    logic        display_ready;
    logic [2:0]  bytes_per_pixel;
    logic [15:0] line_pitch;
    logic [31:0] framebuffer_base;
    logic [31:0] commit_threshold;
  } cfg_t;

  // One queued request: a glyph row (kind pixel) or a single control result
  typedef struct packed {
    kind_t                kind;
    logic                 commit;
    logic [31:0]          row_off;
    logic [PX_OFF_W-1:0]  px_off;
    logic [7:0]           bits;
    logic [31:0]          fg;
  } entry_t;

  // Map odd pixel sizes to one byte
  function automatic logic [2:0] eff_bpp(input logic [2:0] raw);
    logic [2:0] res;
    case (raw)
      3'd2, 3'd3, 3'd4: res = raw;
      default:          res = 3'd1;
    endcase
    return res;
  endfunction

  // Byte mask for an effective pixel size
  function automatic logic [31:0] bpp_mask(input logic [2:0] bpp);
    logic [31:0] res;
    case (bpp)
      3'd2:    res = 32'h0000_FFFF;
      3'd3:    res = 32'h00FF_FFFF;
      3'd4:    res = 32'hFFFF_FFFF;
      default: res = 32'h0000_00FF;
    endcase
    return res;
  endfunction

endpackage

@@ hdl/gcfw_front.sv @@
// Front end: accepts input requests, tracks batch depth and pending count,
// and queues one command per request that yields results. Uses gcfw_pkg.
module gcfw_front #(
  parameter int CELL_HEIGHT = gcfw_pkg::CELL_HEIGHT_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  gcfw_pkg::cfg_t  cfg,
  input  logic            in_push,
  output logic            in_full,
  input  logic [1:0]      in_opcode,
  input  logic [7:0]      in_cell_column,
  input  logic [6:0]      in_cell_line,
  input  logic [3:0]      in_glyph_row_index,
  input  logic [7:0]      in_glyph_bits,
  input  logic [31:0]     in_fg_color,
  output logic            q_push,
  output gcfw_pkg::entry_t q_wdata,
  input  logic            q_full
);

  localparam int          PY_W     = $clog2(128 * CELL_HEIGHT + 16);
  localparam logic [31:0] PEND_INC = 32'(gcfw_pkg::CELL_WIDTH * CELL_HEIGHT);
  localparam logic [31:0] LAST_ROW = 32'(CELL_HEIGHT - 1);

  logic [7:0]  depth_r, depth_nxt;
  logic [31:0] pend_r, pend_nxt;

  logic                         accept;
  logic [2:0]                   bpp;
  logic [PY_W-1:0]              py;
  logic [PY_W+15:0]             prod;
  logic [gcfw_pkg::PX_OFF_W-1:0] px_off;
  logic                         last_row;
  logic [31:0]                  pend_add;
  logic                         want;
  gcfw_pkg::entry_t             ent;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  assign bpp     = gcfw_pkg::eff_bpp(cfg.bytes_per_pixel);

  // Form row and column offsets of the glyph row
  assign py     = PY_W'(in_cell_line) * PY_W'(CELL_HEIGHT) + PY_W'(in_glyph_row_index);
  assign prod   = (PY_W + 16)'(py) * (PY_W + 16)'(cfg.line_pitch);
  assign px_off = gcfw_pkg::PX_OFF_W'({in_cell_column, {gcfw_pkg::COL_SHIFT{1'b0}}})
                * gcfw_pkg::PX_OFF_W'(bpp);

  assign last_row = ({28'd0, in_glyph_row_index} == LAST_ROW);
  assign pend_add = pend_r + PEND_INC;

  // Classify the request and update batch state
  always_comb begin
    depth_nxt      = depth_r;
    pend_nxt       = pend_r;
    want           = 1'b0;
    ent.kind       = gcfw_pkg::KIND_COMMIT;
    ent.commit     = 1'b0;
    ent.row_off    = 32'(prod);
    ent.px_off     = px_off;
    ent.bits       = in_glyph_bits;
    ent.fg         = in_fg_color;
    case (gcfw_pkg::op_t'(in_opcode))
      gcfw_pkg::OP_GLYPH: begin
        want     = 1'b1;
        ent.kind = gcfw_pkg::KIND_PIXEL;
        if (last_row) begin
          if (depth_r == 8'd0 && pend_add >= cfg.commit_threshold) begin
            ent.commit = 1'b1;
            pend_nxt   = 32'd0;
          end else begin
            pend_nxt = pend_add;
          end
        end
      end
      gcfw_pkg::OP_BEGIN: begin
        if (depth_r == 8'd0) begin
          want     = 1'b1;
          ent.kind = gcfw_pkg::KIND_FRAME;
        end
        if (depth_r != 8'hFF) depth_nxt = depth_r + 8'd1;
      end
      gcfw_pkg::OP_END: begin
        if (depth_r == 8'd0) begin
          want     = 1'b1;
          pend_nxt = 32'd0;
        end else begin
          depth_nxt = depth_r - 8'd1;
          if (depth_r == 8'd1) begin
            want     = 1'b1;
            pend_nxt = 32'd0;
          end
        end
      end
      gcfw_pkg::OP_FLUSH: begin
        want     = 1'b1;
        pend_nxt = 32'd0;
      end
      default: begin
        want = 1'b0;
      end
    endcase
  end

  assign q_push  = accept && cfg.display_ready && want;
  assign q_wdata = ent;

  // Hold batch state; advance only on accepted requests while the display is up
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= 8'd0;
      pend_r  <= 32'd0;
    end else if (accept && cfg.display_ready) begin
      depth_r <= depth_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

@@ hdl/gcfw_queue.sv @@
// Short request queue between the front and back ends. Uses gcfw_pkg.
// Register-based; per cycle one write unless full, one read unless empty.
module gcfw_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  gcfw_pkg::entry_t wdata,
  output logic             full,
  input  logic             pop,
  output gcfw_pkg::entry_t rdata,
  output logic             empty
);

  localparam int PTR_W = $clog2(gcfw_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(gcfw_pkg::QUEUE_DEPTH + 1);

  gcfw_pkg::entry_t mem_r [gcfw_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_r, rptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(gcfw_pkg::QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  // Store the request payload
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= wdata;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) wptr_r <= wptr_r + PTR_W'(1);
      if (do_pop)  rptr_r <= rptr_r + PTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ hdl/gcfw_back.sv @@
// Back end: expands queued requests into pixel writes, frame begins and
// commits, one result a cycle unless the output stalls. Uses gcfw_pkg.
module gcfw_back (
  input  logic             clk,
  input  logic             rst_n,
  input  gcfw_pkg::cfg_t   cfg,
  input  gcfw_pkg::entry_t q_rdata,
  input  logic             q_empty,
  output logic             q_pop,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [1:0]       out_kind,
  output logic [31:0]      out_address,
  output logic [31:0]      out_pixel_data,
  output logic [2:0]       out_byte_count,
  output logic             out_last
);

  localparam logic [gcfw_pkg::STEP_W-1:0] LAST_PIX =
    gcfw_pkg::STEP_W'(gcfw_pkg::CELL_WIDTH - 1);
  localparam logic [gcfw_pkg::STEP_W-1:0] NUM_PIX =
    gcfw_pkg::STEP_W'(gcfw_pkg::CELL_WIDTH);

  // Request in progress
  logic                        act_r, act_nxt;
  gcfw_pkg::kind_t             kind_r, kind_nxt;
  logic                        commit_r, commit_nxt;
  logic [gcfw_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [31:0]                 addr_r, addr_nxt;
  logic [7:0]                  bits_r, bits_nxt;
  logic [31:0]                 fg_r, fg_nxt;

  // Output register
  logic        ov_r, ov_nxt;
  gcfw_pkg::kind_t okind_r, okind_nxt;
  logic [31:0] oaddr_r, oaddr_nxt;
  logic [31:0] odata_r, odata_nxt;
  logic [2:0]  ocount_r, ocount_nxt;
  logic        olast_r, olast_nxt;

  logic                        src_valid, adv;
  gcfw_pkg::kind_t             s_kind;
  logic                        s_commit;
  logic [gcfw_pkg::STEP_W-1:0] s_step;
  logic [31:0]                 s_addr, head_addr;
  logic [7:0]                  s_bits;
  logic [31:0]                 s_fg;
  logic [2:0]                  bpp;
  logic                        is_pix, fin;

  assign bpp       = gcfw_pkg::eff_bpp(cfg.bytes_per_pixel);
  assign head_addr = cfg.framebuffer_base + q_rdata.row_off + 32'(q_rdata.px_off);

  // Pick the active request, or the queue head when none is in progress
  always_comb begin
    if (act_r) begin
      s_kind   = kind_r;
      s_commit = commit_r;
      s_step   = step_r;
      s_addr   = addr_r;
      s_bits   = bits_r;
      s_fg     = fg_r;
    end else begin
      s_kind   = q_rdata.kind;
      s_commit = q_rdata.commit;
      s_step   = '0;
      s_addr   = head_addr;
      s_bits   = q_rdata.bits;
      s_fg     = q_rdata.fg;
    end
  end

  assign src_valid = act_r || !q_empty;
  assign adv       = src_valid && (!ov_r || out_pop);
  assign q_pop     = adv && !act_r;
  assign is_pix    = (s_kind == gcfw_pkg::KIND_PIXEL) && (s_step < NUM_PIX);
  assign fin       = !is_pix || (s_step == LAST_PIX && !s_commit);

  // Form the next result and advance the request
  always_comb begin
    act_nxt    = act_r;
    kind_nxt   = kind_r;
    commit_nxt = commit_r;
    step_nxt   = step_r;
    addr_nxt   = addr_r;
    bits_nxt   = bits_r;
    fg_nxt     = fg_r;
    ov_nxt     = ov_r && !out_pop;
    okind_nxt  = okind_r;
    oaddr_nxt  = oaddr_r;
    odata_nxt  = odata_r;
    ocount_nxt = ocount_r;
    olast_nxt  = olast_r;
    if (adv) begin
      ov_nxt = 1'b1;
      if (is_pix) begin
        okind_nxt  = gcfw_pkg::KIND_PIXEL;
        oaddr_nxt  = s_addr;
        odata_nxt  = s_bits[7] ? (s_fg & gcfw_pkg::bpp_mask(bpp)) : 32'd0;
        ocount_nxt = bpp;
      end else begin
        okind_nxt  = (s_kind == gcfw_pkg::KIND_FRAME) ? gcfw_pkg::KIND_FRAME
                                                      : gcfw_pkg::KIND_COMMIT;
        oaddr_nxt  = 32'd0;
        odata_nxt  = 32'd0;
        ocount_nxt = 3'd0;
      end
      olast_nxt  = fin;
      act_nxt    = !fin;
      kind_nxt   = s_kind;
      commit_nxt = s_commit;
      step_nxt   = s_step + gcfw_pkg::STEP_W'(1);
      addr_nxt   = s_addr + 32'(bpp);
      bits_nxt   = {s_bits[6:0], 1'b0};
      fg_nxt     = s_fg;
    end
  end

  // Hold request progress and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      act_r <= act_nxt;
      ov_r  <= ov_nxt;
    end
    kind_r   <= kind_nxt;
    commit_r <= commit_nxt;
    step_r   <= step_nxt;
    addr_r   <= addr_nxt;
    bits_r   <= bits_nxt;
    fg_r     <= fg_nxt;
    okind_r  <= okind_nxt;
    oaddr_r  <= oaddr_nxt;
    odata_r  <= odata_nxt;
    ocount_r <= ocount_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_empty      = !ov_r;
  assign out_kind       = okind_r;
  assign out_address    = oaddr_r;
  assign out_pixel_data = odata_r;
  assign out_byte_count = ocount_r;
  assign out_last       = olast_r;

endmodule

@@ hdl/glyph_cell_framebuffer_writer.sv @@
// Top level of the glyph cell framebuffer writer: configuration registers,
// front end, request queue and back end. Uses gcfw_pkg, gcfw_front,
// gcfw_queue and gcfw_back.
//
//   Channel  Handshake                    Moves
//   in_      push / full                  one request: opcode and glyph row
//   out_     empty / pop                  one result: pixel write, frame, commit
//   cfg_     valid / ready (ready is 1)   one register write by index
//
// A glyph row yields eight pixel writes, and a commit after them when it
// commits; a batch begin, batch end or flush that yields a result yields one,
// and requests that yield no result yield none. The back end gives one
// result per cycle while its output register is free or being popped; the
// front end takes one request a cycle until the four-entry queue fills.
// Reset is synchronous; it empties the queue and output register and clears
// batch depth and pending count. Either side may stall at any time.
module glyph_cell_framebuffer_writer #(
  parameter int CELL_HEIGHT = gcfw_pkg::CELL_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [1:0]                     in_opcode,
  input  logic [7:0]                     in_cell_column,
  input  logic [6:0]                     in_cell_line,
  input  logic [3:0]                     in_glyph_row_index,
  input  logic [7:0]                     in_glyph_bits,
  input  logic [31:0]                    in_fg_color,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [1:0]                     out_kind,
  output logic [31:0]                    out_address,
  output logic [31:0]                    out_pixel_data,
  output logic [2:0]                     out_byte_count,
  output logic                           out_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gcfw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);

  gcfw_pkg::cfg_t   cfg_r;
  gcfw_pkg::entry_t q_wdata, q_rdata;
  logic             q_push, q_full, q_pop, q_empty;

  assign cfg_ready = 1'b1;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.display_ready    <= gcfw_pkg::RST_DISPLAY_READY;
      cfg_r.bytes_per_pixel  <= gcfw_pkg::RST_BYTES_PER_PIXEL;
      cfg_r.line_pitch       <= gcfw_pkg::RST_LINE_PITCH;
      cfg_r.framebuffer_base <= gcfw_pkg::RST_FRAMEBUFFER_BASE;
      cfg_r.commit_threshold <= gcfw_pkg::RST_COMMIT_THRESHOLD;
    end else if (cfg_valid) begin
      case (cfg_index)
        gcfw_pkg::REG_DISPLAY_READY:    cfg_r.display_ready    <= cfg_data[0];
        gcfw_pkg::REG_BYTES_PER_PIXEL:  cfg_r.bytes_per_pixel  <= cfg_data[2:0];
        gcfw_pkg::REG_LINE_PITCH:       cfg_r.line_pitch       <= cfg_data[15:0];
        gcfw_pkg::REG_FRAMEBUFFER_BASE: cfg_r.framebuffer_base <= cfg_data;
        gcfw_pkg::REG_COMMIT_THRESHOLD: cfg_r.commit_threshold <= cfg_data;
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  gcfw_front #(
    .CELL_HEIGHT(CELL_HEIGHT)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_opcode         (in_opcode),
    .in_cell_column    (in_cell_column),
    .in_cell_line      (in_cell_line),
    .in_glyph_row_index(in_glyph_row_index),
    .in_glyph_bits     (in_glyph_bits),
    .in_fg_color       (in_fg_color),
    .q_push            (q_push),
    .q_wdata           (q_wdata),
    .q_full            (q_full)
  );

  gcfw_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .full (q_full),
    .pop  (q_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  gcfw_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .q_rdata       (q_rdata),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_kind      (out_kind),
    .out_address   (out_address),
    .out_pixel_data(out_pixel_data),
    .out_byte_count(out_byte_count),
    .out_last      (out_last)
  );

endmodule

@@ hdl/gcfw_chk.sv @@
// Port-level checker for the glyph cell framebuffer writer, bound to the
// top level. Uses gcfw_pkg and glyph_cell_framebuffer_writer's ports.
module gcfw_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_empty,
  input logic        out_pop,
  input logic [1:0]  out_kind,
  input logic [31:0] out_address,
  input logic [31:0] out_pixel_data,
  input logic [2:0]  out_byte_count,
  input logic        out_last
);

  // Reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result visible right after reset");

  // A stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_kind)
      && $stable(out_address) && $stable(out_pixel_data)
      && $stable(out_byte_count) && $stable(out_last)))
    else $error("stalled result changed");

  // Pixel writes carry one to four bytes, one or two with no data beyond
  a_pix_size: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind == gcfw_pkg::KIND_PIXEL) |->
      (out_byte_count >= 3'd1 && out_byte_count <= 3'd4
       && (out_byte_count != 3'd1 || out_pixel_data[31:8] == 24'd0)
       && (out_byte_count != 3'd2 || out_pixel_data[31:16] == 16'd0)))
    else $error("bad pixel write size or data");

  // Frame begin and commit are bare and always end their request
  a_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind != gcfw_pkg::KIND_PIXEL) |->
      (out_address == 32'd0 && out_pixel_data == 32'd0
       && out_byte_count == 3'd0 && out_last
       && (out_kind == gcfw_pkg::KIND_FRAME || out_kind == gcfw_pkg::KIND_COMMIT)))
    else $error("malformed control result");

endmodule

bind glyph_cell_framebuffer_writer gcfw_chk u_gcfw_chk (.*);

@@ test/gcfw_result_checker.sv @@
// Result checker for the glyph cell framebuffer writer: follows the register,
// request and result channels, predicts every result and compares it.
// Depends on gcfw_pkg for register indexes, opcodes and result kinds.
module gcfw_result_checker #(
  parameter int CELL_HEIGHT = gcfw_pkg::CELL_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  input  logic                           in_full,
  input  logic [1:0]                     in_opcode,
  input  logic [7:0]                     in_cell_column,
  input  logic [6:0]                     in_cell_line,
  input  logic [3:0]                     in_glyph_row_index,
  input  logic [7:0]                     in_glyph_bits,
  input  logic [31:0]                    in_fg_color,
  input  logic                           out_empty,
  input  logic                           out_pop,
  input  logic [1:0]                     out_kind,
  input  logic [31:0]                    out_address,
  input  logic [31:0]                    out_pixel_data,
  input  logic [2:0]                     out_byte_count,
  input  logic                           out_last,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [gcfw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  output int unsigned                    mismatch_count,
  output int unsigned                    results_owed
);

  typedef struct {
    gcfw_pkg::kind_t kind;
    logic [31:0]     address;
    logic [31:0]     pixel_data;
    logic [2:0]      byte_count;
    logic            last;
  } pixel_result_t;

  // Shadow copy of the registers
  logic        disp_ready;
  logic [2:0]  pix_size;
  logic [15:0] pitch;
  logic [31:0] fb_base;
  logic [31:0] threshold;

  // Shadow copy of the block state
  logic [7:0]  nest_depth;
  logic [31:0] pixels_pending;

  pixel_result_t predicted_results[$];
  pixel_result_t burst[$];
  int unsigned   results_seen;

  function automatic pixel_result_t control_result(input gcfw_pkg::kind_t k);
    pixel_result_t r;
    r.kind       = k;
    r.address    = '0;
    r.pixel_data = '0;
    r.byte_count = '0;
    r.last       = 1'b0;
    return r;
  endfunction

  // Queue a commit and clear the pending pixel count
  task automatic issue_commit();
    burst.push_back(control_result(gcfw_pkg::KIND_COMMIT));
    pixels_pending = '0;
  endtask

  // Expand one accepted request into the results it must cause
  task automatic expand_request(input logic [1:0] op, input logic [7:0] col,
                                input logic [6:0] line, input logic [3:0] row,
                                input logic [7:0] bits, input logic [31:0] fg);
    pixel_result_t res;
    logic [31:0]   size;
    logic [31:0]   mask;
    logic [31:0]   line_addr;
    logic [31:0]   px_x;
    burst.delete();
    if (disp_ready) begin
      case (op)
        gcfw_pkg::OP_GLYPH: begin
          size = (pix_size >= 3'd2 && pix_size <= 3'd4) ? 32'(pix_size) : 32'd1;
          mask = (size == 32'd4) ? 32'hFFFF_FFFF : (32'd1 << (8 * size)) - 32'd1;
          line_addr = fb_base + (32'(line) * CELL_HEIGHT + 32'(row)) * 32'(pitch);
          for (int i = 0; i < gcfw_pkg::CELL_WIDTH; i++) begin
            px_x = 32'(col) * gcfw_pkg::CELL_WIDTH + 32'(i);
            res = control_result(gcfw_pkg::KIND_PIXEL);
            res.address    = line_addr + px_x * size;
            res.pixel_data = bits[7-i] ? (fg & mask) : 32'd0;
            res.byte_count = size[2:0];
            burst.push_back(res);
          end
          // Count the cell once its last row is drawn
          if (row == CELL_HEIGHT - 1) begin
            pixels_pending += gcfw_pkg::CELL_WIDTH * CELL_HEIGHT;
            if (nest_depth == 8'd0 && pixels_pending >= threshold) issue_commit();
          end
        end
        gcfw_pkg::OP_BEGIN: begin
          if (nest_depth == 8'd0) burst.push_back(control_result(gcfw_pkg::KIND_FRAME));
          if (nest_depth != 8'hFF) nest_depth++;
        end
        gcfw_pkg::OP_END: begin
          // Hold depth at zero on an unbalanced end, but still commit
          if (nest_depth == 8'd0) begin
            issue_commit();
          end else begin
            nest_depth--;
            if (nest_depth == 8'd0) issue_commit();
          end
        end
        default: issue_commit();
      endcase
    end
    if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
    foreach (burst[i]) predicted_results.push_back(burst[i]);
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < 100)
      $display("result %0d: %s is %h, expected %h", results_seen, field, got, want);
    mismatch_count++;
  endtask

  // Compare the accepted result with the oldest prediction
  task automatic check_result();
    pixel_result_t want;
    if (predicted_results.size() == 0) begin
      report_mismatch("kind of unpredicted result", 32'(out_kind), 32'd0);
    end else begin
      want = predicted_results.pop_front();
      if (out_kind !== want.kind) report_mismatch("kind", 32'(out_kind), 32'(want.kind));
      if (out_address !== want.address)
        report_mismatch("address", out_address, want.address);
      if (out_pixel_data !== want.pixel_data)
        report_mismatch("pixel_data", out_pixel_data, want.pixel_data);
      if (out_byte_count !== want.byte_count)
        report_mismatch("byte_count", 32'(out_byte_count), 32'(want.byte_count));
      if (out_last !== want.last) report_mismatch("last", 32'(out_last), 32'(want.last));
    end
    results_seen++;
  endtask

  // Watch all three channels at each edge
  always @(posedge clk) begin
    if (!rst_n) begin
      disp_ready     = gcfw_pkg::RST_DISPLAY_READY;
      pix_size       = gcfw_pkg::RST_BYTES_PER_PIXEL;
      pitch          = gcfw_pkg::RST_LINE_PITCH;
      fb_base        = gcfw_pkg::RST_FRAMEBUFFER_BASE;
      threshold      = gcfw_pkg::RST_COMMIT_THRESHOLD;
      nest_depth     = '0;
      pixels_pending = '0;
      mismatch_count = 0;
      results_seen   = 0;
      predicted_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gcfw_pkg::REG_DISPLAY_READY:    disp_ready = cfg_data[0];
          gcfw_pkg::REG_BYTES_PER_PIXEL:  pix_size   = cfg_data[2:0];
          gcfw_pkg::REG_LINE_PITCH:       pitch      = cfg_data[15:0];
          gcfw_pkg::REG_FRAMEBUFFER_BASE: fb_base    = cfg_data;
          gcfw_pkg::REG_COMMIT_THRESHOLD: threshold  = cfg_data;
          default: ;
        endcase
      end
      if (in_push && !in_full)
        expand_request(in_opcode, in_cell_column, in_cell_line, in_glyph_row_index,
                       in_glyph_bits, in_fg_color);
      if (out_pop && !out_empty) check_result();
    end
    results_owed = predicted_results.size();
  end

endmodule

@@ test/glyph_cell_framebuffer_writer_test.sv @@
// Testbench top for the glyph cell framebuffer writer: drives requests and
// register writes, pops results and gives the verdict.
// Depends on gcfw_pkg, the block itself and gcfw_result_checker.
module glyph_cell_framebuffer_writer_test;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_push = 1'b0;
  logic                           in_full;
  logic [1:0]                     in_opcode = gcfw_pkg::OP_GLYPH;
  logic [7:0]                     in_cell_column = '0;
  logic [6:0]                     in_cell_line = '0;
  logic [3:0]                     in_glyph_row_index = '0;
  logic [7:0]                     in_glyph_bits = '0;
  logic [31:0]                    in_fg_color = '0;
  logic                           out_empty;
  logic                           out_pop = 1'b0;
  logic [1:0]                     out_kind;
  logic [31:0]                    out_address;
  logic [31:0]                    out_pixel_data;
  logic [2:0]                     out_byte_count;
  logic                           out_last;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [gcfw_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]                    cfg_data = '0;
  int unsigned                    mismatch_count;
  int unsigned                    results_owed;

  logic in_taken = 1'b0;
  logic cfg_taken = 1'b0;
  int   burst_left = 0;
  int   pop_left = 0;
  int   stall_left = 0;

  glyph_cell_framebuffer_writer dut (.*);
  gcfw_result_checker watch (.*);

  always #1 clk = ~clk;

  // Record handshakes for the drivers, which act on the falling edge
  always @(posedge clk) begin
    in_taken  <= rst_n && in_push && !in_full;
    cfg_taken <= rst_n && cfg_valid && cfg_ready;
  end

  // Pop in runs, stalling between them
  always @(negedge clk) begin
    if (pop_left == 0 && stall_left == 0) begin
      pop_left   = $urandom_range(1, 24);
      stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
    end
    if (stall_left > 0) begin
      out_pop <= 1'b0;
      stall_left--;
    end else begin
      out_pop <= 1'b1;
      pop_left--;
    end
  end

  // Drive one request, idling between bursts, and hold it until accepted
  task automatic send_request(input gcfw_pkg::op_t op, input logic [7:0] col,
                              input logic [6:0] line, input logic [3:0] row,
                              input logic [7:0] bits, input logic [31:0] fg);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_push <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_push            <= 1'b1;
    in_opcode          <= op;
    in_cell_column     <= col;
    in_cell_line       <= line;
    in_glyph_row_index <= row;
    in_glyph_bits      <= bits;
    in_fg_color        <= fg;
    do @(negedge clk); while (!in_taken);
    burst_left--;
  endtask

  task automatic send_control(input gcfw_pkg::op_t op);
    send_request(op, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)), $urandom());
  endtask

  // Drop the request line and wait until every predicted result has come
  task automatic await_results();
    in_push <= 1'b0;
    do @(negedge clk); while (results_owed != 0);
  endtask

  // Let the block finish requests that cause no result
  task automatic settle_block();
    await_results();
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input logic [gcfw_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(negedge clk); while (!cfg_taken);
  endtask

  task automatic close_config();
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_config(input logic ready, input logic [2:0] bpp,
                              input logic [15:0] pitch, input logic [31:0] base,
                              input logic [31:0] thr);
    write_reg(gcfw_pkg::REG_DISPLAY_READY, 32'(ready));
    write_reg(gcfw_pkg::REG_BYTES_PER_PIXEL, 32'(bpp));
    write_reg(gcfw_pkg::REG_LINE_PITCH, 32'(pitch));
    write_reg(gcfw_pkg::REG_FRAMEBUFFER_BASE, base);
    write_reg(gcfw_pkg::REG_COMMIT_THRESHOLD, thr);
    close_config();
  endtask

  initial begin : stimulus
    int          cnt;
    int          first;
    bit          wrap;
    bit          paused;
    logic [7:0]  col;
    logic [6:0]  line;
    logic [31:0] fg;
    logic [15:0] pitch;
    logic [31:0] base;
    logic [31:0] thr;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Display not ready yet: every request is dropped
    send_request(gcfw_pkg::OP_GLYPH, 8'd3, 7'd2, 4'd15, 8'hFF, 32'h1);
    send_control(gcfw_pkg::OP_BEGIN);
    send_control(gcfw_pkg::OP_END);
    send_control(gcfw_pkg::OP_FLUSH);
    settle_block();

    // Field extremes, framing and commits at reset geometry
    apply_config(1'b1, gcfw_pkg::RST_BYTES_PER_PIXEL, gcfw_pkg::RST_LINE_PITCH,
                 gcfw_pkg::RST_FRAMEBUFFER_BASE, gcfw_pkg::RST_COMMIT_THRESHOLD);
    send_request(gcfw_pkg::OP_GLYPH, 8'd255, 7'd127, 4'd15, 8'hFF, 32'hFFFF_FFFF);
    send_request(gcfw_pkg::OP_GLYPH, 8'd0, 7'd0, 4'd0, 8'h00, 32'h0);
    send_request(gcfw_pkg::OP_GLYPH, 8'd17, 7'd3, 4'd7, 8'hA5, 32'h1234_5678);
    send_control(gcfw_pkg::OP_BEGIN);
    send_control(gcfw_pkg::OP_BEGIN);
    send_request(gcfw_pkg::OP_GLYPH, 8'd40, 7'd9, 4'd15, 8'h3C, 32'hCAFE_F00D);
    send_control(gcfw_pkg::OP_END);
    send_control(gcfw_pkg::OP_END);
    send_control(gcfw_pkg::OP_END);
    send_control(gcfw_pkg::OP_FLUSH);
    settle_block();

    // Every pixel size, odd ones included, with wrapping addresses and zero threshold
    write_reg(gcfw_pkg::REG_LINE_PITCH, 32'hFFFF);
    write_reg(gcfw_pkg::REG_FRAMEBUFFER_BASE, 32'hFFFF_FFF0);
    write_reg(gcfw_pkg::REG_COMMIT_THRESHOLD, 32'h0);
    close_config();
    for (int s = 0; s < 8; s++) begin
      settle_block();
      write_reg(gcfw_pkg::REG_BYTES_PER_PIXEL, 32'(s));
      close_config();
      send_request(gcfw_pkg::OP_GLYPH, 8'($urandom_range(0, 255)),
                   7'($urandom_range(0, 127)), 4'd15, 8'h5A, 32'hA1B2_C3D4);
    end
    settle_block();

    // Nesting: a few levels deep, unwind them, then one end too many
    write_reg(gcfw_pkg::REG_BYTES_PER_PIXEL, 32'd2);
    close_config();
    repeat (3) send_control(gcfw_pkg::OP_BEGIN);
    send_request(gcfw_pkg::OP_GLYPH, 8'd1, 7'd1, 4'd15, 8'hF0, 32'h00AB_CDEF);
    repeat (4) send_control(gcfw_pkg::OP_END);

    // Random phases: mostly whole cells, some framing and noise
    paused = 1'b0;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: begin
          pitch = 16'hFFFF;
          base  = 32'h0;
        end
        1: begin
          pitch = 16'h0;
          base  = 32'hFFFF_FFFF;
        end
        default: begin
          pitch = 16'($urandom_range(1, 65535));
          base  = $urandom();
        end
      endcase
      case ($urandom_range(0, 4))
        0:       thr = 32'd0;
        1:       thr = 32'd128;
        2:       thr = 32'(128 * $urandom_range(2, 6));
        3:       thr = 32'($urandom_range(1, 1000));
        default: thr = 32'd4096;
      endcase
      if (ph == 5) thr = 32'hFFFF_FFFF;
      settle_block();
      apply_config(1'b1, (ph < 4) ? 3'(ph + 1) : 3'($urandom_range(0, 7)), pitch, base, thr);
      cnt = 0;
      while (cnt < 34) begin
        // Hold off once mid-phase until the block has drained
        if (ph == 2 && cnt >= 20 && !paused) begin
          await_results();
          paused = 1'b1;
        end
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            col   = 8'($urandom_range(0, 255));
            line  = 7'($urandom_range(0, 127));
            fg    = $urandom();
            first = $urandom_range(0, 1) ? 0 : $urandom_range(0, 15);
            wrap  = ($urandom_range(0, 2) == 0);
            if (wrap) send_control(gcfw_pkg::OP_BEGIN);
            for (int r = first; r < 16; r++)
              send_request(gcfw_pkg::OP_GLYPH, col, line, 4'(r),
                           8'($urandom_range(0, 255)), fg);
            if (wrap) send_control(gcfw_pkg::OP_END);
            cnt += 16 - first + (wrap ? 2 : 0);
          end
          6: begin
            send_control(gcfw_pkg::OP_BEGIN);
            cnt++;
          end
          7: begin
            send_control(gcfw_pkg::OP_END);
            cnt++;
          end
          8: begin
            send_control(gcfw_pkg::OP_FLUSH);
            cnt++;
          end
          default: begin
            send_request(gcfw_pkg::op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                         7'($urandom_range(0, 127)), 4'($urandom_range(0, 15)),
                         8'($urandom_range(0, 255)), $urandom());
            cnt++;
          end
        endcase
      end
    end

    // Drain and give the verdict
    await_results();
    repeat (40) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("glyph_cell_framebuffer_writer_test: done, clean");
    end else begin
      $display("glyph_cell_framebuffer_writer_test: done, errors");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #1000000;
    $display("glyph_cell_framebuffer_writer_test: done, errors");
    $finish;
  end

endmodule

@@ files.f @@
hdl/gcfw_pkg.sv
hdl/gcfw_front.sv
hdl/gcfw_queue.sv
hdl/gcfw_back.sv
hdl/glyph_cell_framebuffer_writer.sv
hdl/gcfw_chk.sv
test/gcfw_result_checker.sv
test/glyph_cell_framebuffer_writer_test.sv
